@@ design/fssc_pkg.sv @@
`timescale 1ns / 1ps

package fssc_pkg;

  localparam int unsigned MU_W = 3;
  localparam logic [MU_W-1:0] MAX_MU = 3'd6;

  // ceil(2^35 / 10), exact quotient of a 32-bit value by ten after >> 35
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SHIFT = 35;

  // clamp value for a loaded subframe
  localparam logic [3:0] LAST_SUBFRAME = 4'd9;

  typedef enum logic {
    REQ_ADVANCE = 1'b0,
    REQ_LOAD    = 1'b1
  } req_t;

  typedef struct packed {
    req_t        req_type;
    logic [31:0] slot_count;
    logic [55:0] load_value;
    logic [7:0]  sym_start;
  } item_t;

  // count already split by numerology, quotient by ten reduced mod 2^16
  typedef struct packed {
    req_t        req_type;
    logic [15:0] cq_div;
    logic [3:0]  cq_rem;
    logic [5:0]  cr;
    logic [15:0] ld_frame;
    logic [3:0]  ld_subframe;
    logic [5:0]  ld_slot;
    logic [7:0]  sym_start;
  } prep_t;

  typedef struct packed {
    logic [15:0] frame;
    logic [3:0]  subframe;
    logic [5:0]  slot;
    logic [25:0] slot_index;
    logic [55:0] encoded;
  } result_t;

  function automatic logic [5:0] slot_mask(input logic [MU_W-1:0] mu);
    logic [5:0] one;
    one = 6'd1;
    // at the largest numerology the shift leaves zero and the mask is all ones
    return (one << mu) - 6'd1;
  endfunction

endpackage

@@ design/fssc_prep.sv @@
`timescale 1ns / 1ps

module fssc_prep (
  input  logic                       clk,
  input  logic                       en,
  input  fssc_pkg::item_t            item,
  input  logic [fssc_pkg::MU_W-1:0]  mu,
  output fssc_pkg::prep_t            prep_r
);

  logic [31:0]     cq;
  logic [63:0]     prod;
  logic [15:0]     q_lo;
  logic [5:0]      mask;
  logic [7:0]      ld_sf;
  fssc_pkg::prep_t prep_nxt;

  always_comb begin
    mask  = fssc_pkg::slot_mask(mu);
    cq    = item.slot_count >> mu;
    prod  = 64'(cq) * 64'(fssc_pkg::RECIP10);
    q_lo  = prod[fssc_pkg::RECIP10_SHIFT +: 16];
    ld_sf = item.load_value[31:24];

    prep_nxt.req_type    = item.req_type;
    prep_nxt.cq_div      = q_lo;
    // remainder needs only the low nibble of cq - 10 * quotient
    prep_nxt.cq_rem      = cq[3:0] - (q_lo[3:0] * 4'd10);
    prep_nxt.cr          = item.slot_count[5:0] & mask;
    prep_nxt.ld_frame    = item.load_value[47:32];
    prep_nxt.ld_subframe = (ld_sf > 8'(fssc_pkg::LAST_SUBFRAME)) ?
                           fssc_pkg::LAST_SUBFRAME : ld_sf[3:0];
    prep_nxt.ld_slot     = item.load_value[13:8] & mask;
    prep_nxt.sym_start   = item.sym_start;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

@@ design/fssc_update.sv @@
`timescale 1ns / 1ps

module fssc_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  fssc_pkg::prep_t            prep,
  input  logic [fssc_pkg::MU_W-1:0]  mu,
  output fssc_pkg::result_t          res_r
);

  logic [15:0] frame_r, frame_nxt;
  logic [3:0]  subframe_r, subframe_nxt;
  logic [5:0]  slot_r, slot_nxt;

  logic [6:0]  sum7;
  logic [6:0]  carry;
  logic [7:0]  s8;
  logic [15:0] s_prod;
  logic [4:0]  sd;
  logic [7:0]  s_rem;
  logic [19:0] base;
  logic [25:0] idx;
  fssc_pkg::result_t res_nxt;

  always_comb begin
    // slot plus low part of count, whatever spills over goes to the subframe
    sum7   = {1'b0, slot_r} + {1'b0, prep.cr};
    carry  = sum7 >> mu;
    s8     = 8'(subframe_r) + 8'(prep.cq_rem) + 8'(carry);
    s_prod = 16'(s8) * 16'd205;
    sd     = s_prod[15:11];
    s_rem  = s8 - (8'(sd) * 8'd10);

    unique case (prep.req_type)
      fssc_pkg::REQ_ADVANCE: begin
        frame_nxt    = frame_r + prep.cq_div + 16'(sd);
        subframe_nxt = s_rem[3:0];
        slot_nxt     = sum7[5:0] & fssc_pkg::slot_mask(mu);
      end
      fssc_pkg::REQ_LOAD: begin
        frame_nxt    = prep.ld_frame;
        subframe_nxt = prep.ld_subframe;
        slot_nxt     = prep.ld_slot;
      end
      default: begin
        frame_nxt    = frame_r;
        subframe_nxt = subframe_r;
        slot_nxt     = slot_r;
      end
    endcase

    base = (20'(frame_nxt) << 3) + (20'(frame_nxt) << 1) + 20'(subframe_nxt);
    idx  = (26'(base) << mu) + 26'(slot_nxt);

    res_nxt.frame      = frame_nxt;
    res_nxt.subframe   = subframe_nxt;
    res_nxt.slot       = slot_nxt;
    res_nxt.slot_index = idx;
    res_nxt.encoded    = {5'd0, mu, frame_nxt, 4'd0, subframe_nxt,
                          10'd0, slot_nxt, prep.sym_start};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r    <= '0;
      subframe_r <= '0;
      slot_r     <= '0;
    end else if (en) begin
      frame_r    <= frame_nxt;
      subframe_r <= subframe_nxt;
      slot_r     <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ design/frame_subframe_slot_counter.sv @@
`timescale 1ns / 1ps

// Frame / subframe / slot timing counter.
// Input channel (in_valid, in_stall): each item either advances the
// position by in_slot_count slots or loads it from in_load_value.
// Result channel (out_valid, out_stall): one result per item, carrying the
// new frame, subframe, slot, the flat slot index and the packed encoding
// with in_sym_start in the low byte.
// Config channel (cfg_valid, cfg_ready): writes the 3-bit numerology;
// cfg_ready is always high. Write it only while no item is in flight.
// Three register stages: an input register, a stage that splits the count
// by numerology and divides it by ten with one 32x32 reciprocal multiply,
// and the position update feeding the result register. out_valid rises once
// the item has passed the input, prep and result registers. Throughput is
// one item per cycle while out_stall is low.
// Each stage moves up when the one after it is empty or moving, so the
// block keeps taking items while a result waits under out_stall until all
// three stages are full; then in_stall rises.
// Reset clears the position to frame 0, subframe 0, slot 0, numerology to
// 0 and empties the pipeline.
module frame_subframe_slot_counter (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_slot_count,
  input  logic [55:0] in_load_value,
  input  logic [7:0]  in_sym_start,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_frame_out,
  output logic [3:0]  out_subframe_out,
  output logic [5:0]  out_slot_out,
  output logic [25:0] out_slot_index,
  output logic [55:0] out_encoded,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_numerology
);

  logic [fssc_pkg::MU_W-1:0] numerology_r;
  logic [fssc_pkg::MU_W-1:0] mu;

  logic v_a_r, v_b_r, v_c_r;
  logic rdy_a, rdy_b, rdy_c;

  fssc_pkg::item_t   item_r;
  fssc_pkg::prep_t   prep_r;
  fssc_pkg::result_t res_r;

  assign cfg_ready = 1'b1;
  assign mu = (numerology_r > fssc_pkg::MAX_MU) ? fssc_pkg::MAX_MU : numerology_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numerology_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      numerology_r <= cfg_numerology;
    end
  end

  assign rdy_c    = !v_c_r || !out_stall;
  assign rdy_b    = !v_b_r || rdy_c;
  assign rdy_a    = !v_a_r || rdy_b;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        v_a_r <= in_valid;
      end
      if (rdy_b) begin
        v_b_r <= v_a_r;
      end
      if (rdy_c) begin
        v_c_r <= v_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      item_r.req_type   <= fssc_pkg::req_t'(in_req_type);
      item_r.slot_count <= in_slot_count;
      item_r.load_value <= in_load_value;
      item_r.sym_start  <= in_sym_start;
    end
  end

  fssc_prep u_prep (
    .clk    (clk),
    .en     (v_a_r && rdy_b),
    .item   (item_r),
    .mu     (mu),
    .prep_r (prep_r)
  );

  // position state advances exactly once per item, in order
  fssc_update u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (v_b_r && rdy_c),
    .prep  (prep_r),
    .mu    (mu),
    .res_r (res_r)
  );

  assign out_valid        = v_c_r;
  assign out_frame_out    = res_r.frame;
  assign out_subframe_out = res_r.subframe;
  assign out_slot_out     = res_r.slot;
  assign out_slot_index   = res_r.slot_index;
  assign out_encoded      = res_r.encoded;

endmodule

@@ design/fssc_checker.sv @@
`timescale 1ns / 1ps

module fssc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_frame_out,
  input logic [3:0]  out_subframe_out,
  input logic [5:0]  out_slot_out,
  input logic [25:0] out_slot_index,
  input logic [55:0] out_encoded
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_encoded)
      && $stable(out_slot_index))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_subframe_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_subframe_out <= 4'd9)
    else $error("subframe out of range");

  a_encoding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_encoded[47:32] == out_frame_out
      && out_encoded[31:24] == {4'd0, out_subframe_out}
      && out_encoded[23:8] == {10'd0, out_slot_out})
    else $error("encoding does not match position fields");

  a_mu_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_encoded[55:48] <= 8'(fssc_pkg::MAX_MU))
    else $error("numerology in encoding above maximum");

endmodule

bind frame_subframe_slot_counter fssc_checker u_fssc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_out    (out_frame_out),
  .out_subframe_out (out_subframe_out),
  .out_slot_out     (out_slot_out),
  .out_slot_index   (out_slot_index),
  .out_encoded      (out_encoded)
);
